/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define HTE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hte assertion failed");

// An implication checked in the same cycle.
`define HTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hte assertion failed");

`endif

/* rtl/hte_pkg.sv */
// ----------------------------------------------------------------------------
// hte_pkg
// Shared constants, types and functions of the hysteresis event detector.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int CHANNELS     = 4;
    localparam int SAMPLE_BITS  = 10;
    localparam int MARGIN_BITS  = 10;
    localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_BITS     = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS) + 2;

    localparam int S_TDATA_BITS = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = CH_BITS + 1 + SAMPLE_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [MARGIN_BITS-1:0] RISE_RESET = MARGIN_BITS'(50);
    localparam logic [MARGIN_BITS-1:0] FALL_RESET = MARGIN_BITS'(10);

    // register indexes on the config channel
    localparam logic [CFG_IDX_BITS-1:0] REG_RISE_MARGIN = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FALL_MARGIN = CFG_IDX_BITS'(1);

    // mode codes carried on s_tuser
    localparam logic MODE_CHECK     = 1'b0;
    localparam logic MODE_CALIBRATE = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [MARGIN_BITS-1:0] margin_t;

    typedef struct packed {
        logic change;
        logic now_triggered;
    } lane_stat_t;

    typedef struct packed {
        logic               event_valid;
        logic [CH_BITS-1:0] channel;
        logic               now_triggered;
        sample_t            event_sample;
    } result_t;

    // sample + floor(3 * (full scale - sample) / 4), kept to SAMPLE_BITS
    function automatic sample_t cal_level(input sample_t smp);
        logic [SAMPLE_BITS:0]   headroom;
        logic [SAMPLE_BITS+2:0] triple;
        logic [SAMPLE_BITS+2:0] total;
        headroom = (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;
        headroom = headroom - {1'b0, smp};
        triple   = {headroom, 1'b0} + {2'b00, headroom};
        total    = {3'b000, smp} + (triple >> 2);
        return total[SAMPLE_BITS-1:0];
    endfunction

endpackage

/* rtl/hysteresis_threshold_event_detector_top.sv */
// ----------------------------------------------------------------------------
// hysteresis_threshold_event_detector_top
// Multichannel hysteresis comparator with first-change event report.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one transaction per sample set. s_tdata holds the channel samples,
//         channel 0 in the lowest bits; s_tuser is the mode (0 check,
//         1 calibrate trigger levels).
//   m_* : exactly one result transaction per input transaction, in order.
//         m_tuser is event_valid; with it low the tdata fields are zero.
//   cfg_*: register writes (index 0 rise margin, index 1 fall margin),
//         always ready; write only while no result is outstanding.
// Result: on m_tvalid the cycle after its input is taken, unless the output stalls.
// Throughput: one item per cycle while s_tready is high. The per-lane compare,
//   the priority pick and the flag update all close in the single accept cycle,
//   so the state the next item sees is already current.
// Stall: an output register plus a one-entry skid register; s_tready drops
//   only once both hold results the receiver has not taken.
// Reset: levels and flags clear, margins return to 50 and 10, no results
//   pending, s_tready high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hysteresis_threshold_event_detector_top
    import hte_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // sample_0, sample_1, ... (low first)
    input  logic                    s_tuser,   // mode

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // channel, now_triggered, event_sample
    output logic                    m_tuser,   // event_valid

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  margin_t                 cfg_data
);

    // ---------------- configuration registers ----------------
    margin_t rise_reg;
    margin_t rise_next;
    margin_t fall_reg;
    margin_t fall_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rise_next = rise_reg;
        fall_next = fall_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RISE_MARGIN: rise_next = cfg_data;
                REG_FALL_MARGIN: fall_next = cfg_data;
                default:         ;   // unknown index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg <= RISE_RESET;
            fall_reg <= FALL_RESET;
        end
        else
        begin
            rise_reg <= rise_next;
            fall_reg <= fall_next;
        end
    end

    // ---------------- lanes ----------------
    logic                in_fire;
    logic                calibrate;
    logic                check;
    sample_t             sample [CHANNELS];
    lane_stat_t          stat   [CHANNELS];
    logic [CHANNELS-1:0] grant;
    result_t             res;

    assign in_fire   = s_tvalid && s_tready;
    assign calibrate = in_fire && (s_tuser == MODE_CALIBRATE);
    assign check     = (s_tuser == MODE_CHECK);

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        assign sample[g] = s_tdata[g*SAMPLE_BITS +: SAMPLE_BITS];

        hte_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .sample      (sample[g]),
            .calibrate   (calibrate),
            .toggle      (in_fire && grant[g]),
            .rise_margin (rise_reg),
            .fall_margin (fall_reg),
            .stat        (stat[g])
        );
    end

    // priority pick across lanes; grant also steers the flag flip
    hte_merge u_merge (
        .check  (check),
        .stat   (stat),
        .sample (sample),
        .res    (res),
        .grant  (grant)
    );

    // ---------------- output register + skid ----------------
    logic [M_TDATA_BITS-1:0] new_data;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [M_TDATA_BITS-1:0] out_data_reg;
    logic [M_TDATA_BITS-1:0] out_data_next;
    logic                    out_user_reg;
    logic                    out_user_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [M_TDATA_BITS-1:0] skid_data_reg;
    logic [M_TDATA_BITS-1:0] skid_data_next;
    logic                    skid_user_reg;
    logic                    skid_user_next;
    logic                    out_fire;

    assign new_data = M_TDATA_BITS'({res.event_sample, res.now_triggered, res.channel});
    assign out_fire = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_user_next   = skid_user_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_data_next = new_data;
                out_user_next = res.event_valid;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_data;
                skid_user_next  = res.event_valid;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = new_data;
                out_user_next  = res.event_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ---------------- assertions ----------------
    `HTE_ASSERT(a_grant_onehot0, $onehot0(grant))
    `HTE_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `HTE_ASSERT_IMP(a_no_event_zero, m_tvalid && !m_tuser, m_tdata == '0)

endmodule

/* rtl/hte_lane.sv */
// ----------------------------------------------------------------------------
// hte_lane
// One channel: trigger level, triggered flag and the hysteresis compare.
// ----------------------------------------------------------------------------
module hte_lane
    import hte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sample_t    sample,
    input  logic       calibrate,   // load a new trigger level this cycle
    input  logic       toggle,      // this lane won the event, flip its flag
    input  margin_t    rise_margin,
    input  margin_t    fall_margin,
    output lane_stat_t stat
);

    sample_t level_reg;
    sample_t level_next;
    logic    flag_reg;
    logic    flag_next;

    logic signed [CMP_BITS-1:0] smp_s;
    logic signed [CMP_BITS-1:0] upper_s;
    logic signed [CMP_BITS-1:0] lower_s;

    // signed bounds, no saturation: a bound out of range never fires
    always_comb
    begin
        smp_s   = $signed(CMP_BITS'(sample));
        upper_s = $signed(CMP_BITS'(level_reg)) + $signed(CMP_BITS'(rise_margin));
        lower_s = $signed(CMP_BITS'(level_reg)) - $signed(CMP_BITS'(fall_margin));
        stat.change        = flag_reg ? (smp_s < lower_s) : (smp_s > upper_s);
        stat.now_triggered = ~flag_reg;
    end

    always_comb
    begin
        level_next = calibrate ? cal_level(sample) : level_reg;
        flag_next  = toggle ? ~flag_reg : flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

/* rtl/hte_merge.sv */
// ----------------------------------------------------------------------------
// hte_merge
// Picks the lowest channel that changed and forms the event result.
// ----------------------------------------------------------------------------
module hte_merge
    import hte_pkg::*;
(
    input  logic                check,
    input  lane_stat_t          stat   [CHANNELS],
    input  sample_t             sample [CHANNELS],
    output result_t             res,
    output logic [CHANNELS-1:0] grant
);

    logic found;

    always_comb
    begin
        found = 1'b0;
        grant = '0;
        res   = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (check && stat[i].change && !found)
            begin
                found             = 1'b1;
                grant[i]          = 1'b1;
                res.event_valid   = 1'b1;
                res.channel       = CH_BITS'(i);
                res.now_triggered = stat[i].now_triggered;
                res.event_sample  = sample[i];
            end
        end
    end

endmodule

/* test/tb_hysteresis_threshold_event_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hysteresis_threshold_event_detector_top
// Self-checking bench for the four-channel hysteresis event detector.
// Sample sets are streamed in under randomized gaps and back-pressure. A
// scoreboard class keeps its own trigger levels, trigger flags and margins,
// predicts the one result that each accepted sample set causes, and compares
// every returned result field by field, in order.
// ----------------------------------------------------------------------------
module tb_hysteresis_threshold_event_detector_top
    import hte_pkg::*;
();

    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 5;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the detector state plus the queue of results
    // still owed by the block.
    // ------------------------------------------------------------------------
    class detector_scoreboard;
        sample_t level [CHANNELS];
        bit      armed [CHANNELS];
        margin_t rise;
        margin_t fall;
        result_t expected_events [$];
        int      errors;

        function new();
            for (int i = 0; i < CHANNELS; i++)
            begin
                level[i] = '0;
                armed[i] = 1'b0;
            end
            rise   = RISE_RESET;
            fall   = FALL_RESET;
            errors = 0;
        endfunction

        function void set_margin(logic [CFG_IDX_BITS-1:0] idx, margin_t val);
            if (idx == REG_RISE_MARGIN)
                rise = val;
            else if (idx == REG_FALL_MARGIN)
                fall = val;
        endfunction

        // Called once per accepted sample set; works out the owed result.
        function void predict_event(logic mode, logic [S_TDATA_BITS-1:0] data);
            result_t r;
            int      smp;
            int      lvl;
            bit      flip;
            r = '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                smp = int'(data[i*SAMPLE_BITS +: SAMPLE_BITS]);
                lvl = int'(level[i]);
                if (mode == MODE_CALIBRATE)
                begin
                    // three-quarter point between sample and full scale
                    level[i] = sample_t'(smp + (3 * ((SAMPLE_MAX + 1) - smp)) / 4);
                end
                else
                begin
                    // signed compare, no clamp: bounds outside 0..max never fire
                    if (armed[i])
                        flip = smp < lvl - int'(fall);
                    else
                        flip = smp > lvl + int'(rise);
                    if (flip)
                    begin
                        armed[i]        = !armed[i];
                        r.event_valid   = 1'b1;
                        r.channel       = CH_BITS'(i);
                        r.now_triggered = armed[i];
                        r.event_sample  = sample_t'(smp);
                        break;
                    end
                end
            end
            expected_events.push_back(r);
        endfunction

        function void report(string field, int want, int got);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            errors++;
        endfunction

        function void check_event(logic valid_bit, logic [M_TDATA_BITS-1:0] data);
            result_t want;
            if (expected_events.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual tuser=%0b tdata=%h",
                         $time, valid_bit, data);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (valid_bit !== want.event_valid)
                report("event_valid", want.event_valid, valid_bit);
            if (data[CH_BITS-1:0] !== want.channel)
                report("channel", want.channel, data[CH_BITS-1:0]);
            if (data[CH_BITS] !== want.now_triggered)
                report("now_triggered", want.now_triggered, data[CH_BITS]);
            if (data[CH_BITS+1 +: SAMPLE_BITS] !== want.event_sample)
                report("event_sample", want.event_sample, data[CH_BITS+1 +: SAMPLE_BITS]);
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;     // sample_0 .. sample_3, low first
    logic                    s_tuser;     // mode
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;     // channel, now_triggered, event_sample
    logic                    m_tuser;     // event_valid
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    margin_t                 cfg_data;

    detector_scoreboard sb = new();

    // traffic knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // long receiver hold-off, requested by stimulus, timed by the receiver
    logic hold_request = 1'b0;
    bit   hold_taken   = 1'b0;
    int   hold_left    = 0;

    int cycles = 0;

    hysteresis_threshold_event_detector_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: checks each result transaction, then picks the next tready.
    // Values are sampled at the edge, before the block's own updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_event(m_tuser, m_tdata);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [S_TDATA_BITS-1:0] pack_samples(int a, int b, int c, int d);
        logic [S_TDATA_BITS-1:0] data;
        data = '0;
        data[0*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(a);
        data[1*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(b);
        data[2*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(c);
        data[3*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(d);
        return data;
    endfunction

    // One sample-set transaction. tvalid is left high on return so a
    // back-to-back item does not lower and raise it in the same step.
    task automatic send_item(input logic mode, input logic [S_TDATA_BITS-1:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.predict_event(mode, data);
    endtask

    // Random sets: half of the samples sit within two of each channel's
    // current switching bound, the rest are extremes and uniform noise.
    task automatic send_random(input int count);
        logic [S_TDATA_BITS-1:0] data;
        logic                    mode;
        int                      pick;
        int                      val;
        for (int n = 0; n < count; n++)
        begin
            mode = ($urandom_range(99) < 8) ? MODE_CALIBRATE : MODE_CHECK;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                    val = $urandom_range(1) ? SAMPLE_MAX : 0;
                else if (pick < 50)
                    val = $urandom_range(SAMPLE_MAX);
                else
                begin
                    if (sb.armed[ch])
                        val = int'(sb.level[ch]) - int'(sb.fall);
                    else
                        val = int'(sb.level[ch]) + int'(sb.rise);
                    val = val + int'($urandom_range(4)) - 2;
                    if (val < 0)
                        val = 0;
                    if (val > SAMPLE_MAX)
                        val = SAMPLE_MAX;
                end
                data[ch*SAMPLE_BITS +: SAMPLE_BITS] = sample_t'(val);
            end
            send_item(mode, data);
        end
    endtask

    // Stop offering and wait until every owed result is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; called only with the block drained.
    task automatic write_margin(input logic [CFG_IDX_BITS-1:0] idx, input margin_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_margin(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_CHECK;
        cfg_valid = 1'b0;
        cfg_index = REG_RISE_MARGIN;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset margins (rise 50, fall 10), levels all zero.
        // Rise bound is exact: 50 stays idle, 51 trips.
        send_item(MODE_CHECK, pack_samples(0, 0, 0, 0));
        send_item(MODE_CHECK, pack_samples(50, 0, 0, 0));
        // ch1 would also trip but only the lowest changing channel counts
        send_item(MODE_CHECK, pack_samples(51, 1023, 0, 0));
        // ch0 can not release: level - fall is below zero
        send_item(MODE_CHECK, pack_samples(51, 1023, 0, 0));
        send_item(MODE_CHECK, pack_samples(0, 0, 1023, 1023));
        send_item(MODE_CHECK, pack_samples(0, 0, 1023, 1023));
        // calibrate: levels 768, 1023, 896, 768; flags stay set
        send_item(MODE_CALIBRATE, pack_samples(0, 1023, 512, 1));
        // releases one channel per set, lowest first
        repeat (4) send_item(MODE_CHECK, pack_samples(0, 0, 0, 0));
        // re-trigger; ch1 never trips since level + rise passes full scale
        repeat (4) send_item(MODE_CHECK, pack_samples(1023, 1023, 1023, 1023));
        send_item(MODE_CALIBRATE, pack_samples(1023, 0, 1023, 0));
        send_item(MODE_CHECK, pack_samples(1, 1022, 818, 1023));

        // Phase: no idling at all.
        send_random(85);
        drain();

        // Phase: zero margins, sender idle most cycles.
        write_margin(REG_RISE_MARGIN, margin_t'(0));
        write_margin(REG_FALL_MARGIN, margin_t'(0));
        idle_pct  = 73;
        stall_pct = 0;
        send_random(100);
        drain();

        // Phase: rise at max (never trips), receiver stalls most cycles.
        write_margin(REG_RISE_MARGIN, margin_t'(SAMPLE_MAX));
        idle_pct  = 0;
        stall_pct = 73;
        send_random(100);
        drain();

        // Phase: fall at max (never releases), light idling on both sides.
        write_margin(REG_RISE_MARGIN, margin_t'(0));
        write_margin(REG_FALL_MARGIN, margin_t'(SAMPLE_MAX));
        idle_pct  = 8;
        stall_pct = 8;
        send_random(100);
        drain();

        // Phase: random margins, long receiver hold-off while the sender
        // keeps offering, so the output stage fills and s_tready drops.
        write_margin(REG_RISE_MARGIN, margin_t'($urandom_range(120)));
        write_margin(REG_FALL_MARGIN, margin_t'($urandom_range(120)));
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request <= 1'b1;
        send_random(100);
        drain();

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
